@@ rtl/pbi_pkg.sv @@
// pbi_pkg: shared types and constants of the pedal breakpoint interpolator
// no dependencies; used by every module of the block by scoped names

package pbi_pkg;

  // configuration register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MV_PER_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BP_BASE      = 3'd2;

  // register fields
  localparam int CNT_W    = 3;
  localparam int SCALE_W  = 24;
  localparam int FRAC_W   = 16;
  localparam int VOLT_W   = 16;
  localparam int PCT_W    = 16;
  localparam int BP_W     = 32;
  localparam int NUM_BP   = 6;
  localparam int MV_RESET = 423226;

  // segment arithmetic
  localparam int DIFF_W    = 17;
  localparam int NUM_W     = 33;
  localparam int MAG_W     = 32;
  localparam int DIV_W     = 16;
  localparam int ACC_W     = MAG_W + DIV_W;
  localparam int PCT_SUM_W = 34;

  // output scaling
  localparam int POS_W       = 10;
  localparam int POS_MAX     = 1000;
  localparam int PCT_SAT     = 10010;
  localparam int PCT_LOW_W   = 14;
  localparam int RECIP_W     = 16;
  localparam int RECIP_10    = 52429;
  localparam int RECIP_SHIFT = 19;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef logic [NUM_BP-1:0][BP_W-1:0] bp_array_t;

  // one division job: pct = pp + trunc(num / den), den never zero
  typedef struct packed {
    logic [PCT_W-1:0]         pp;
    logic signed [NUM_W-1:0]  num;
    logic signed [DIFF_W-1:0] den;
  } div_req_t;

  // quotient magnitude with its sign and the base percent
  typedef struct packed {
    logic [MAG_W-1:0] quo;
    logic             neg;
    logic [PCT_W-1:0] pp;
  } div_res_t;

  // one restoring division step: acc holds {remainder, dividend or quotient bits}
  function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                 input logic [DIV_W-1:0] dvs);
    logic [DIV_W:0]   top;
    logic [DIV_W:0]   diff;
    logic [ACC_W-1:0] res;
    top  = acc[ACC_W-1:MAG_W-1];
    diff = top - {1'b0, dvs};
    if (top >= {1'b0, dvs}) begin
      res = {diff[DIV_W-1:0], acc[MAG_W-2:0], 1'b1};
    end else begin
      res = {top[DIV_W-1:0], acc[MAG_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

@@ rtl/pbi_front.sv @@
// pbi_front: accepts samples, scales to millivolts, picks the breakpoint segment
// and forms the numerator and span of the interpolation; uses pbi_pkg

module pbi_front #(
  parameter int ADC_BITS   = 9,
  parameter int MAX_POINTS = 6
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic [ADC_BITS-1:0]                   adc_sample,
  input  logic                                  inhibit,
  input  logic [pbi_pkg::CNT_W-1:0]             point_count,
  input  logic [pbi_pkg::SCALE_W-1:0]           mv_per_count,
  input  pbi_pkg::bp_array_t                    bp,
  output logic                                  push,
  output pbi_pkg::div_req_t                     push_req
);

  localparam int PROD_W = ADC_BITS + pbi_pkg::SCALE_W;
  localparam int MV_W   = PROD_W - pbi_pkg::FRAC_W;
  localparam int SEL_W  = pbi_pkg::CNT_W;

  // stage 0: captured sample
  logic                s0_valid;
  logic [ADC_BITS-1:0] s0_sample;
  logic                s0_zero;

  // stage 1: scaled product
  logic              s1_valid;
  logic              s1_zero;
  logic [PROD_W-1:0] s1_prod;

  // stage 2: chosen segment
  logic                            s2_valid;
  logic                            s2_interp;
  logic [pbi_pkg::PCT_W-1:0]       s2_const;
  logic [pbi_pkg::VOLT_W-1:0]      s2_mv;
  logic [pbi_pkg::VOLT_W-1:0]      s2_pv;
  logic [pbi_pkg::PCT_W-1:0]       s2_pp;
  logic [pbi_pkg::VOLT_W-1:0]      s2_cv;
  logic [pbi_pkg::PCT_W-1:0]       s2_cp;

  // stage 3: differences
  logic                             s3_valid;
  logic [pbi_pkg::PCT_W-1:0]        s3_pp;
  logic signed [pbi_pkg::DIFF_W-1:0] s3_dx;
  logic signed [pbi_pkg::DIFF_W-1:0] s3_dp;
  logic signed [pbi_pkg::DIFF_W-1:0] s3_den;

  // stage 4: numerator product, goes to the queue
  logic              s4_valid;
  pbi_pkg::div_req_t s4_req;

  logic [SEL_W-1:0] n_eff;
  logic [SEL_W-1:0] last_idx;
  logic [MV_W-1:0]  mv;
  logic [SEL_W-1:0] seg;
  logic [SEL_W-1:0] seg_prev;
  logic             found;

  logic [pbi_pkg::PCT_W-1:0]         pp_next;
  logic signed [pbi_pkg::DIFF_W-1:0] dx_next;
  logic signed [pbi_pkg::DIFF_W-1:0] dp_next;
  logic signed [pbi_pkg::DIFF_W-1:0] den_next;
  logic signed [2*pbi_pkg::DIFF_W-1:0] num_full;

  assign n_eff    = (point_count > SEL_W'(MAX_POINTS)) ? SEL_W'(MAX_POINTS) : point_count;
  assign last_idx = n_eff - 1'b1;
  assign mv       = s1_prod[PROD_W-1:pbi_pkg::FRAC_W];

  // first breakpoint at or above the voltage, lowest index wins
  always_comb begin
    seg   = '0;
    found = 1'b0;
    for (int i = pbi_pkg::NUM_BP - 1; i >= 1; i--) begin
      if ((SEL_W'(i) < n_eff) && (mv <= MV_W'(bp[i][pbi_pkg::BP_W-1:pbi_pkg::PCT_W]))) begin
        seg   = SEL_W'(i);
        found = 1'b1;
      end
    end
  end

  assign seg_prev = seg - 1'b1;

  // segment repair: constant result and equal voltages become num 0, den 1
  always_comb begin
    pp_next  = s2_pp;
    dx_next  = $signed({1'b0, s2_mv}) - $signed({1'b0, s2_pv});
    dp_next  = $signed({1'b0, s2_cp}) - $signed({1'b0, s2_pp});
    den_next = $signed({1'b0, s2_cv}) - $signed({1'b0, s2_pv});
    if (!s2_interp) begin
      pp_next  = s2_const;
      dx_next  = '0;
      dp_next  = '0;
      den_next = pbi_pkg::DIFF_W'(1);
    end else if (s2_cv == s2_pv) begin
      pp_next  = s2_cp;
      dx_next  = '0;
      dp_next  = '0;
      den_next = pbi_pkg::DIFF_W'(1);
    end
  end

  assign num_full = s3_dx * s3_dp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_sample <= adc_sample;
      s0_zero   <= inhibit || (n_eff == '0);
    end
    s1_zero <= s0_zero;
    s1_prod <= PROD_W'(s0_sample) * PROD_W'(mv_per_count);

    s2_interp <= found && !s1_zero;
    s2_const  <= s1_zero ? '0 : bp[last_idx][pbi_pkg::PCT_W-1:0];
    s2_mv     <= mv[pbi_pkg::VOLT_W-1:0];
    s2_pv     <= bp[seg_prev][pbi_pkg::BP_W-1:pbi_pkg::PCT_W];
    s2_pp     <= bp[seg_prev][pbi_pkg::PCT_W-1:0];
    s2_cv     <= bp[seg][pbi_pkg::BP_W-1:pbi_pkg::PCT_W];
    s2_cp     <= bp[seg][pbi_pkg::PCT_W-1:0];

    s3_pp  <= pp_next;
    s3_dx  <= dx_next;
    s3_dp  <= dp_next;
    s3_den <= den_next;

    s4_req.pp  <= s3_pp;
    s4_req.num <= num_full[pbi_pkg::NUM_W-1:0];
    s4_req.den <= s3_den;
  end

  assign push     = s4_valid;
  assign push_req = s4_req;

  // the span handed to the divider is never zero
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> (s4_req.den != '0))
    else $error("zero divisor reached the queue");

endmodule

@@ rtl/pbi_queue.sv @@
// pbi_queue: short word queue between the front and the divider back end
// uses pbi_pkg for the job type and depth

module pbi_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pbi_pkg::div_req_t push_req,
  output logic              pop,
  output pbi_pkg::div_req_t pop_req,
  output logic              full
);

  pbi_pkg::div_req_t               mem [pbi_pkg::Q_DEPTH];
  logic [pbi_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [pbi_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [pbi_pkg::Q_CNT_W-1:0]     count;

  // the back end never stalls, so the head leaves whenever present
  assign pop     = (count != '0);
  assign pop_req = mem[rd_ptr];
  assign full    = (count == pbi_pkg::Q_CNT_W'(pbi_pkg::Q_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_req;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue overflow");

endmodule

@@ rtl/pbi_div.sv @@
// pbi_div: pipelined signed divider, one quotient bit per stage, truncates toward zero
// uses pbi_pkg for the job types and the step function

module pbi_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pbi_pkg::div_req_t in_req,
  output logic              out_valid,
  output pbi_pkg::div_res_t out_res
);

  localparam int STAGES = pbi_pkg::MAG_W;

  logic [STAGES:0]                 st_valid;
  logic [pbi_pkg::ACC_W-1:0]       st_acc [STAGES+1];
  logic [pbi_pkg::DIV_W-1:0]       st_dvs [STAGES+1];
  logic                            st_neg [STAGES+1];
  logic [pbi_pkg::PCT_W-1:0]       st_pp  [STAGES+1];

  logic signed [pbi_pkg::NUM_W-1:0]  num_abs;
  logic signed [pbi_pkg::DIFF_W-1:0] den_abs;

  assign num_abs = in_req.num[pbi_pkg::NUM_W-1] ? -in_req.num : in_req.num;
  assign den_abs = in_req.den[pbi_pkg::DIFF_W-1] ? -in_req.den : in_req.den;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else begin
      st_valid <= {st_valid[STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    st_acc[0] <= {{pbi_pkg::DIV_W{1'b0}}, num_abs[pbi_pkg::MAG_W-1:0]};
    st_dvs[0] <= den_abs[pbi_pkg::DIV_W-1:0];
    st_neg[0] <= in_req.num[pbi_pkg::NUM_W-1] ^ in_req.den[pbi_pkg::DIFF_W-1];
    st_pp[0]  <= in_req.pp;
    for (int k = 0; k < STAGES; k++) begin
      st_acc[k+1] <= pbi_pkg::div_step(st_acc[k], st_dvs[k]);
      st_dvs[k+1] <= st_dvs[k];
      st_neg[k+1] <= st_neg[k];
      st_pp[k+1]  <= st_pp[k];
    end
  end

  assign out_valid   = st_valid[STAGES];
  assign out_res.quo = st_acc[STAGES][pbi_pkg::MAG_W-1:0];
  assign out_res.neg = st_neg[STAGES];
  assign out_res.pp  = st_pp[STAGES];

  // a finished division leaves a remainder below the divisor
  a_rem_below_dvs: assert property (@(posedge clk) disable iff (rst)
    st_valid[STAGES] |-> (st_acc[STAGES][pbi_pkg::ACC_W-1:pbi_pkg::MAG_W] < st_dvs[STAGES]))
    else $error("divider remainder out of range");

endmodule

@@ rtl/pbi_back.sv @@
// pbi_back: adds the signed quotient to the base percent, scales to tenths,
// saturates and registers the result with its strobe; uses pbi_pkg

module pbi_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      res_valid,
  input  pbi_pkg::div_res_t         res,
  output logic                      done,
  output logic [pbi_pkg::POS_W-1:0] position_tenths
);

  localparam int SCL_W = pbi_pkg::PCT_LOW_W + pbi_pkg::RECIP_W;

  logic                                  b1_valid;
  logic signed [pbi_pkg::PCT_SUM_W-1:0]  b1_pct;

  logic signed [pbi_pkg::PCT_SUM_W-1:0]  quo_s;
  logic signed [pbi_pkg::PCT_SUM_W-1:0]  pct_next;
  logic [SCL_W-1:0]                      scaled;
  logic [pbi_pkg::POS_W-1:0]             pos_next;

  assign quo_s    = res.neg ? -$signed({2'b00, res.quo}) : $signed({2'b00, res.quo});
  assign pct_next = quo_s + $signed({{(pbi_pkg::PCT_SUM_W-pbi_pkg::PCT_W){1'b0}}, res.pp});

  // divide by ten through a reciprocal, exact for the range below saturation
  assign scaled = SCL_W'(b1_pct[pbi_pkg::PCT_LOW_W-1:0]) * SCL_W'(pbi_pkg::RECIP_10);

  always_comb begin
    priority if (b1_pct[pbi_pkg::PCT_SUM_W-1]) begin
      pos_next = '0;
    end else if (b1_pct >= $signed(pbi_pkg::PCT_SUM_W'(pbi_pkg::PCT_SAT))) begin
      pos_next = pbi_pkg::POS_W'(pbi_pkg::POS_MAX);
    end else begin
      pos_next = scaled[pbi_pkg::RECIP_SHIFT +: pbi_pkg::POS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      b1_valid <= res_valid;
      done     <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    b1_pct          <= pct_next;
    position_tenths <= pos_next;
  end

endmodule

@@ rtl/pedal_breakpoint_interpolator_core.sv @@
// pedal_breakpoint_interpolator_core: top level with configuration registers,
// front end, queue, pipelined divider and back end; uses pbi_pkg and all pbi_* modules
//
//   channel   signals                          direction  handshake
//   --------  -------------------------------  ---------  --------------------------------
//   sample    start, busy, adc_sample, inhibit  in         taken when start && !busy
//   result    done, position_tenths             out        one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_index, cfg_data       in         written when cfg_we, no wait
//
// a sample can be taken every cycle; busy only rises if the queue fills, which the
// back end prevents by draining one word per cycle
// a sample passes the five front stages, one queue stage, the 32-stage divider (one
// quotient bit per stage) and two back registers on its way to done
// rst is synchronous: it empties every pipeline stage and restores the registers
// the receiver cannot stall, so nothing in the back end ever holds a result

module pedal_breakpoint_interpolator_core #(
  parameter int ADC_BITS   = 9,
  parameter int MAX_POINTS = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  // sample channel
  input  logic                              start,
  output logic                              busy,
  input  logic [ADC_BITS-1:0]               adc_sample,
  input  logic                              inhibit,
  // result channel
  output logic                              done,
  output logic [pbi_pkg::POS_W-1:0]         position_tenths,
  // configuration port
  input  logic                              cfg_we,
  input  logic [pbi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbi_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  logic [pbi_pkg::CNT_W-1:0]    point_count;
  logic [pbi_pkg::SCALE_W-1:0]  mv_per_count;
  pbi_pkg::bp_array_t           bp;
  logic [pbi_pkg::CFG_IDX_W-1:0] bp_sel;

  // front to queue
  logic              push;
  pbi_pkg::div_req_t push_req;

  // queue to divider
  logic              pop;
  pbi_pkg::div_req_t pop_req;
  logic              q_full;

  // divider to back end
  logic              res_valid;
  pbi_pkg::div_res_t res;

  logic accept;

  assign busy   = q_full;
  assign accept = start && !busy;

  // breakpoint registers follow the two scalar registers in the map
  assign bp_sel = cfg_index - pbi_pkg::REG_BP_BASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= '0;
      mv_per_count <= pbi_pkg::SCALE_W'(pbi_pkg::MV_RESET);
      bp           <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pbi_pkg::REG_POINT_COUNT:  point_count  <= cfg_data[pbi_pkg::CNT_W-1:0];
        pbi_pkg::REG_MV_PER_COUNT: mv_per_count <= cfg_data[pbi_pkg::SCALE_W-1:0];
        default:                   bp[bp_sel]   <= cfg_data[pbi_pkg::BP_W-1:0];
      endcase
    end
  end

  // front: scale, segment search, numerator product
  pbi_front #(
    .ADC_BITS   (ADC_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .adc_sample   (adc_sample),
    .inhibit      (inhibit),
    .point_count  (point_count),
    .mv_per_count (mv_per_count),
    .bp           (bp),
    .push         (push),
    .push_req     (push_req)
  );

  // decoupling queue
  pbi_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .pop_req  (pop_req),
    .full     (q_full)
  );

  // back: long division, one bit per stage
  pbi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop),
    .in_req    (pop_req),
    .out_valid (res_valid),
    .out_res   (res)
  );

  // back: add, scale to tenths, saturate
  pbi_back u_back (
    .clk             (clk),
    .rst             (rst),
    .res_valid       (res_valid),
    .res             (res),
    .done            (done),
    .position_tenths (position_tenths)
  );

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (position_tenths <= pbi_pkg::POS_W'(pbi_pkg::POS_MAX)))
    else $error("position above full scale");

  a_no_busy_drain: assert property (@(posedge clk) disable iff (rst)
    push |=> !q_full)
    else $error("queue filled although the back end drains every cycle");

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for pedal_breakpoint_interpolator_core
// depends on pbi_pkg and the core; directed curves first, then random curves and samples

module tb_top;
  import pbi_pkg::*;

  localparam int ADC_BITS    = 9;
  localparam int MAX_POINTS  = 6;
  localparam int CYCLE_LIMIT = 250000;
  localparam int RAND_PHASES = 14;
  localparam int WORDS_PER_PHASE = 75;
  localparam int DRAIN_CYCLES = 48;

  // one sample word as the driver presents it
  typedef struct packed {
    logic [ADC_BITS-1:0] sample;
    logic                inh;
  } pedal_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // all block inputs start at known values
  logic                  start      = 1'b0;
  logic [ADC_BITS-1:0]   adc_sample = '0;
  logic                  inhibit    = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  logic              busy;
  logic              done;
  logic [POS_W-1:0]  position_tenths;

  // shadow copy of the register file, only changed while the block is idle
  logic [CNT_W-1:0]   cnt_r   = '0;
  logic [SCALE_W-1:0] scale_r = SCALE_W'(MV_RESET);
  logic [BP_W-1:0]    bp_r [NUM_BP];

  pedal_word_t      sample_backlog [$];   // words waiting for the driver
  logic [POS_W-1:0] pos_due [$];          // predicted positions, oldest first
  pedal_word_t      cur_word;
  logic [POS_W-1:0] want_pos;
  int               gap_left = 0;
  bit               burst = 1'b0;         // phase with no idle cycles at all
  int               mismatches = 0;
  int unsigned      cycle_count = 0;

  pedal_breakpoint_interpolator_core #(
    .ADC_BITS  (ADC_BITS),
    .MAX_POINTS(MAX_POINTS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .adc_sample     (adc_sample),
    .inhibit        (inhibit),
    .done           (done),
    .position_tenths(position_tenths),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  // expected position for one sample under the current shadow registers
  function automatic logic [POS_W-1:0] tenths_for(input logic [ADC_BITS-1:0] smp,
                                                   input logic inh);
    longint mv, pv, pp, cv, cp, pct, pos;
    int     n;
    bit     hit;
    n = (cnt_r > MAX_POINTS) ? MAX_POINTS : int'(cnt_r);
    if (inh || n == 0) return '0;
    // millivolts from the q16 scale, exact
    mv  = (longint'(smp) * longint'(scale_r)) >> FRAC_W;
    pv  = longint'(bp_r[0][BP_W-1:PCT_W]);
    pp  = longint'(bp_r[0][PCT_W-1:0]);
    hit = 1'b0;
    pct = 0;
    for (int i = 1; i < n; i++) begin
      if (!hit) begin
        cv = longint'(bp_r[i][BP_W-1:PCT_W]);
        cp = longint'(bp_r[i][PCT_W-1:0]);
        if (mv <= cv) begin
          hit = 1'b1;
          // a zero span takes the current percent, else signed slope truncated to zero
          if (cv == pv) pct = cp;
          else pct = pp + ((mv - pv) * (cp - pp)) / (cv - pv);
        end else begin
          pv = cv;
          pp = cp;
        end
      end
    end
    // past the last breakpoint the last percent holds
    if (!hit) pct = pp;
    pos = pct / 10;
    if (pos < 0) pos = 0;
    if (pos > POS_MAX) pos = POS_MAX;
    return POS_W'(pos);
  endfunction

  // idle cycles before the next word: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic [BP_W-1:0] bp(input int volt, input int pct);
    return {volt[VOLT_W-1:0], pct[PCT_W-1:0]};
  endfunction

  // driver: offers the next backlog word once the previous one is taken
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      // word taken at this edge: predict with the values the block saw
      if (start && !busy) pos_due.push_back(tenths_for(adc_sample, inhibit));
      // a word held off by busy stays on the ports untouched
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          cur_word   = sample_backlog.pop_front();
          adc_sample <= cur_word.sample;
          inhibit    <= cur_word.inh;
          start      <= 1'b1;
          gap_left   = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each done strobe is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pos_due.size() == 0) begin
        $error("position_tenths: no word expected, got %0d", position_tenths);
        mismatches++;
      end else begin
        want_pos = pos_due.pop_front();
        if (position_tenths !== want_pos) begin
          $error("position_tenths: expected %0d, got %0d", want_pos, position_tenths);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_word(input int smp, input bit inh);
    pedal_word_t w;
    w.sample = ADC_BITS'(smp);
    w.inh    = inh;
    sample_backlog.push_back(w);
  endtask

  // wait until every word has been taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || start || pos_due.size() != 0);
  endtask

  // write the whole register file from the shadow copy, one register per edge
  task automatic apply_settings();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_POINT_COUNT;
    cfg_data  <= CFG_DATA_W'(cnt_r);
    @(posedge clk);
    cfg_index <= REG_MV_PER_COUNT;
    cfg_data  <= CFG_DATA_W'(scale_r);
    @(posedge clk);
    for (int k = 0; k < NUM_BP; k++) begin
      cfg_index <= REG_BP_BASE + CFG_IDX_W'(k);
      cfg_data  <= bp_r[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_curve(input int cnt, input int scale, input logic [BP_W-1:0] b0,
                           input logic [BP_W-1:0] b1, input logic [BP_W-1:0] b2,
                           input logic [BP_W-1:0] b3, input logic [BP_W-1:0] b4,
                           input logic [BP_W-1:0] b5);
    cnt_r   = CNT_W'(cnt);
    scale_r = SCALE_W'(scale);
    bp_r[0] = b0;
    bp_r[1] = b1;
    bp_r[2] = b2;
    bp_r[3] = b3;
    bp_r[4] = b4;
    bp_r[5] = b5;
    apply_settings();
  endtask

  // random curve: mostly sorted voltages up to an eighth above the reachable millivolt span
  task automatic random_settings();
    int mode, top, t, pct;
    int vlt [NUM_BP];
    mode = $urandom_range(0, 9);
    cnt_r = ($urandom_range(0, 6) == 0) ? CNT_W'($urandom_range(0, 7))
                                        : CNT_W'($urandom_range(2, 6));
    case ($urandom_range(0, 9))
      0:       scale_r = '1;
      1:       scale_r = '0;
      2, 3:    scale_r = SCALE_W'($urandom);
      default: scale_r = SCALE_W'($urandom_range(150000, 700000));
    endcase
    top = int'((longint'(511) * longint'(scale_r)) >> FRAC_W);
    top = top + top / 8 + 1;
    if (top > 65535) top = 65535;
    if (mode == 0) begin
      // raw noise in every register bit
      for (int k = 0; k < NUM_BP; k++) bp_r[k] = $urandom;
    end else begin
      for (int k = 0; k < NUM_BP; k++) vlt[k] = $urandom_range(0, top);
      for (int k = 0; k < NUM_BP; k++) begin
        for (int j = 0; j < NUM_BP - 1; j++) begin
          if (vlt[j] > vlt[j+1]) begin
            t        = vlt[j];
            vlt[j]   = vlt[j+1];
            vlt[j+1] = t;
          end
        end
      end
      // flat step in the curve
      if (mode < 3) begin
        t = $urandom_range(1, NUM_BP - 1);
        vlt[t] = vlt[t-1];
      end
      pct = $urandom_range(0, 2000);
      for (int k = 0; k < NUM_BP; k++) begin
        // mode 4 walks the voltages downward
        t = (mode == 4) ? vlt[NUM_BP-1-k] : vlt[k];
        if (mode == 3) pct = $urandom_range(0, 65535);
        bp_r[k] = bp(t, pct);
        pct = pct + $urandom_range(0, 3000);
        if (pct > 65535) pct = 65535;
      end
    end
    apply_settings();
  endtask

  initial begin
    for (int k = 0; k < NUM_BP; k++) bp_r[k] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // no breakpoints: always zero, inhibit too
    set_curve(0, MV_RESET, 0, 0, 0, 0, 0, 0);
    queue_word(0, 0);
    queue_word(511, 0);
    queue_word(511, 1);
    wait_drained();

    // single breakpoint gives its own percent everywhere
    burst = 1'b1;
    set_curve(1, MV_RESET, bp(1234, 5678), 0, 0, 0, 0, 0);
    queue_word(0, 0);
    queue_word(511, 0);
    wait_drained();

    // full ascending curve: below the first point, flat segment, above 100 percent
    burst = 1'b0;
    set_curve(6, MV_RESET, bp(500, 0), bp(1000, 2500), bp(1500, 2500),
              bp(2000, 9000), bp(2500, 12000), bp(3000, 65535));
    queue_word(0, 0);
    queue_word(511, 0);
    queue_word(155, 0);
    queue_word(511, 1);
    queue_word(300, 0);
    queue_word(400, 0);
    queue_word(77, 0);
    wait_drained();

    // count above the limit, full scale, equal first voltages, falling segment
    set_curve(7, 24'hFFFFFF, bp(40000, 3000), bp(40000, 6000), bp(30000, 100),
              bp(65535, 0), bp(0, 9), bp(65535, 65535));
    queue_word(0, 0);
    queue_word(100, 0);
    queue_word(250, 0);
    queue_word(511, 0);
    queue_word(400, 1);
    wait_drained();

    // first span negative: divides by a negative voltage difference
    burst = 1'b1;
    set_curve(2, MV_RESET, bp(3000, 9000), bp(1000, 200), 0, 0, 0, 0);
    queue_word(0, 0);
    queue_word(50, 0);
    queue_word(154, 0);
    queue_word(155, 0);
    queue_word(511, 0);
    wait_drained();

    // zero scale: every sample reads as zero millivolts
    burst = 1'b0;
    set_curve(3, 0, bp(100, 700), bp(200, 800), bp(300, 900), 0, 0, 0);
    queue_word(511, 0);
    queue_word(123, 0);
    wait_drained();

    // random curves with random samples, edges of the sample range now and then
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      burst = ($urandom_range(0, 3) == 0);
      random_settings();
      for (int w = 0; w < WORDS_PER_PHASE; w++) begin
        case ($urandom_range(0, 19))
          0:       queue_word(0, $urandom_range(0, 9) == 0);
          1:       queue_word(511, $urandom_range(0, 9) == 0);
          default: queue_word($urandom_range(0, 511), $urandom_range(0, 9) == 0);
        endcase
      end
      wait_drained();
    end

    // let any stray strobe show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ pedal_breakpoint_interpolator_core.f @@
rtl/pbi_pkg.sv
rtl/pbi_front.sv
rtl/pbi_queue.sv
rtl/pbi_div.sv
rtl/pbi_back.sv
rtl/pedal_breakpoint_interpolator_core.sv
verif/tb_top.sv
